### design/vsa_pkg.sv
// Shared types and constants for the variable store ALU.
package vsa_pkg;

    localparam int VSA_VAR_COUNT = 256;
    localparam int DATA_W        = 32;

    localparam logic [7:0] TYPE_IMMEDIATE = 8'hFF;
    localparam logic [7:0] TYPE_VARIABLE  = 8'hFE;

    typedef enum logic [4:0] {
        OP_SET     = 5'd0,
        OP_ADD     = 5'd1,
        OP_SUB     = 5'd2,
        OP_MUL     = 5'd3,
        OP_DIV     = 5'd4,
        OP_AND     = 5'd5,
        OP_OR      = 5'd6,
        OP_NOT     = 5'd7,
        OP_GT      = 5'd8,
        OP_EQ      = 5'd9,
        OP_LT      = 5'd10,
        OP_NE      = 5'd11,
        OP_WAIT_GT = 5'd12,
        OP_WAIT_EQ = 5'd13,
        OP_WAIT_LT = 5'd14,
        OP_WAIT_NE = 5'd15,
        OP_MOD     = 5'd16,
        OP_READ    = 5'd17
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_src;
        logic op_load_fixed;
        logic op_load_mem;
        logic cur_load;
        logic exec;
        logic div_start;
        logic div_take;
        logic mem_write;
        logic clear_write;
        logic out_load;
    } vsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fail;
        logic type_var;
        logic div_req;
        logic div_done;
        logic clear_last;
        logic out_busy;
    } vsa_status_t;

endpackage

### design/vsa_if.sv
// Command and response channel interfaces.
interface vsa_cmd_if;
    logic               valid;
    logic               ready;
    logic [4:0]         op;
    logic [31:0]        var_index;
    logic [7:0]         type_code;
    logic signed [31:0] immediate_value;
    logic [31:0]        source_index;

    modport source (output valid, op, var_index, type_code, immediate_value, source_index,
                    input ready);
    modport sink (input valid, op, var_index, type_code, immediate_value, source_index,
                  output ready);
endinterface

interface vsa_rsp_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [31:0] read_value;

    modport source (output valid, status, read_value, input ready);
    modport sink (input valid, status, read_value, output ready);
endinterface

### design/vsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/vsa_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
module vsa_div import vsa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    localparam int CW = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W+1:0] diff;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // restore when the trial subtract goes negative
            if (diff[DATA_W+1])
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/vsa_ctrl.sv
// Command sequencer for the variable store ALU.
module vsa_ctrl import vsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  vsa_status_t status,
    output vsa_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_CHECK    = 9'b000000100,
        S_LOAD_SRC = 9'b000001000,
        S_LOAD_TGT = 9'b000010000,
        S_EXEC     = 9'b000100000,
        S_DIVIDE   = 9'b001000000,
        S_WRITE    = 9'b010000000,
        S_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = 1'b1;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.op_load_fixed = 1'b1;
                cmd.rd_src        = status.type_var;
                if (status.fail)
                begin
                    state_next = S_FINISH;
                end
                else if (status.type_var)
                begin
                    state_next = S_LOAD_SRC;
                end
                else
                begin
                    state_next = S_LOAD_TGT;
                end
            end
            S_LOAD_SRC:
            begin
                cmd.op_load_mem = 1'b1;
                state_next      = S_LOAD_TGT;
            end
            S_LOAD_TGT:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.div_req)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the response register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/vsa_dp.sv
// Datapath: command registers, variable store, ALU, divider and response register.
module vsa_dp import vsa_pkg::*; #(
    parameter int VAR_COUNT = VSA_VAR_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vsa_cmd_t           cmd,
    output vsa_status_t        status,
    input  logic [4:0]         op,
    input  logic [31:0]        var_index,
    input  logic [7:0]         type_code,
    input  logic signed [31:0] immediate_value,
    input  logic [31:0]        source_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_status,
    output logic signed [31:0] out_value
);

    localparam int AW = $clog2(VAR_COUNT);

    logic [4:0]        op_reg;
    logic [31:0]       tgt_reg;
    logic [7:0]        type_reg;
    logic [31:0]       imm_reg;
    logic [31:0]       src_reg;
    logic [DATA_W-1:0] operand_reg, operand_next;
    logic [DATA_W-1:0] cur_reg;
    logic [DATA_W-1:0] result_reg, result_next;
    logic              wstat_reg, wstat_next;
    logic [AW-1:0]     clear_cnt_reg;
    logic              out_valid_reg;
    logic              out_status_reg;
    logic [DATA_W-1:0] out_value_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    logic              bad_tgt;
    logic              bad_src;
    logic              type_var;
    logic              is_div;
    logic              is_mod;
    logic              neg_a;
    logic              neg_b;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              div_done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] div_fixed;
    logic signed [DATA_W-1:0] sc;
    logic signed [DATA_W-1:0] so;
    logic [2*DATA_W-1:0] product;
    op_t               opc;

    assign opc      = op_t'(op_reg);
    assign type_var = (type_reg == TYPE_VARIABLE);
    assign bad_tgt  = (tgt_reg >= 32'(VAR_COUNT));
    assign bad_src  = type_var && (src_reg >= 32'(VAR_COUNT));
    assign is_div   = (opc == OP_DIV);
    assign is_mod   = (opc == OP_MOD);

    assign status.fail       = bad_tgt || bad_src;
    assign status.type_var   = type_var;
    assign status.div_req    = (is_div || is_mod) && (operand_reg != '0);
    assign status.div_done   = div_done;
    assign status.clear_last = (clear_cnt_reg == AW'(VAR_COUNT - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;

    // store access
    assign raddr = cmd.rd_src ? src_reg[AW-1:0] : tgt_reg[AW-1:0];
    assign we    = cmd.mem_write || cmd.clear_write;
    assign waddr = cmd.clear_write ? clear_cnt_reg : tgt_reg[AW-1:0];
    assign wdata = cmd.clear_write ? '0 : result_reg;

    vsa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VAR_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // divider takes magnitudes, signs fixed afterwards
    assign neg_a = cur_reg[DATA_W-1];
    assign neg_b = operand_reg[DATA_W-1];
    assign mag_a = neg_a ? (DATA_W'(0) - cur_reg) : cur_reg;
    assign mag_b = neg_b ? (DATA_W'(0) - operand_reg) : operand_reg;

    vsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        if (is_mod)
        begin
            div_fixed = neg_a ? (DATA_W'(0) - rem) : rem;
        end
        else
        begin
            div_fixed = (neg_a != neg_b) ? (DATA_W'(0) - quo) : quo;
        end
    end

    assign operand_next = (type_reg == TYPE_IMMEDIATE) ? imm_reg : {24'd0, type_reg};

    assign sc      = $signed(cur_reg);
    assign so      = $signed(operand_reg);
    assign product = cur_reg * operand_reg;

    always_comb
    begin
        result_next = cur_reg;
        wstat_next  = 1'b0;
        case (opc)
            OP_SET:     result_next = operand_reg;
            OP_ADD:     result_next = cur_reg + operand_reg;
            OP_SUB:     result_next = cur_reg - operand_reg;
            OP_MUL:     result_next = product[DATA_W-1:0];
            OP_AND:     result_next = DATA_W'((cur_reg != '0) && (operand_reg != '0));
            OP_OR:      result_next = DATA_W'((cur_reg != '0) || (operand_reg != '0));
            OP_NOT:     result_next = DATA_W'(cur_reg == '0);
            OP_GT:      result_next = DATA_W'(sc > so);
            OP_EQ:      result_next = DATA_W'(cur_reg == operand_reg);
            OP_LT:      result_next = DATA_W'(sc < so);
            OP_NE:      result_next = DATA_W'(cur_reg != operand_reg);
            OP_WAIT_GT: wstat_next  = !(sc > so);
            OP_WAIT_EQ: wstat_next  = (cur_reg != operand_reg);
            OP_WAIT_LT: wstat_next  = !(sc < so);
            OP_WAIT_NE: wstat_next  = (cur_reg == operand_reg);
            default:    result_next = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            tgt_reg  <= var_index;
            type_reg <= type_code;
            imm_reg  <= immediate_value;
            src_reg  <= source_index;
        end
        if (cmd.op_load_fixed)
        begin
            operand_reg <= operand_next;
        end
        else if (cmd.op_load_mem)
        begin
            operand_reg <= rdata;
        end
        if (cmd.cur_load)
        begin
            cur_reg <= rdata;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
            wstat_reg  <= wstat_next;
        end
        else if (cmd.div_take)
        begin
            result_reg <= div_fixed;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status.fail ? 1'b1 : wstat_reg;
            out_value_reg  <= status.fail ? '0 : result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_write)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = $signed(out_value_reg);

endmodule

### design/variable_store_alu.sv
// Top level of the variable store ALU.
//
// Executes one script command per word on a store of VAR_COUNT signed 32-bit
// variables held in a single-port-read RAM. After reset a clearing pass writes
// zero to every variable, one per cycle; no command is taken until it ends.
// A command then steps through check, target load, execute, write, finish,
// with a source load before the target load when the operand is another
// variable (the store has one read port, so source and target are read in
// turn), plus a divide step for div and mod with a nonzero divisor, which
// runs the one-bit-per-cycle divider and then takes its result. A command
// with a bad target or source index skips from check to finish. The response
// sits in an output register, so the next command is taken while it waits.
module variable_store_alu import vsa_pkg::*; #(
    parameter int VAR_COUNT = VSA_VAR_COUNT
) (
    input logic        clk,
    input logic        rst_n,
    vsa_cmd_if.sink    cmd_in,
    vsa_rsp_if.source  rsp_out
);

    vsa_cmd_t    cmd;
    vsa_status_t status;
    logic        in_ready;

    assign cmd_in.ready = in_ready;

    vsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vsa_dp #(
        .VAR_COUNT (VAR_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (cmd_in.op),
        .var_index       (cmd_in.var_index),
        .type_code       (cmd_in.type_code),
        .immediate_value (cmd_in.immediate_value),
        .source_index    (cmd_in.source_index),
        .out_valid       (rsp_out.valid),
        .out_ready       (rsp_out.ready),
        .out_status      (rsp_out.status),
        .out_value       (rsp_out.read_value)
    );

endmodule
